FILE: rtl/core/sst_pkg.sv
// Shared types and constants for the speech segment tracker.
// Self-contained; used by speech_segment_tracker.
`default_nettype none

package sst_pkg;

  // Fixed field and register widths.
  localparam int unsigned ProbBits  = 16;
  localparam int unsigned LenBits   = 32;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned OutBits   = 32;

  // Hysteresis band width, 0.15 in Q0.16.
  localparam logic [ProbBits-1:0] BandWidth = 16'd9830;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CFG_SPEECH_THRESHOLD = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_WINDOW_SAMPLES   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_MIN_SILENCE_LEN  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_MIN_SPEECH_LEN   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_SPEECH_LEN   = 3'd4;
  localparam logic [CfgIdxBits-1:0] CFG_LONG_SILENCE_LEN = 3'd5;

  // Configuration reset values.
  localparam logic [ProbBits-1:0] RstSpeechThreshold = 16'd6554;
  localparam logic [ProbBits-1:0] RstWindowSamples   = 16'd512;
  localparam logic [LenBits-1:0]  RstMinSilenceLen   = 32'd0;
  localparam logic [LenBits-1:0]  RstMinSpeechLen    = 32'd1024;
  localparam logic [LenBits-1:0]  RstMaxSpeechLen    = 32'hFFFF_FFFF;
  localparam logic [LenBits-1:0]  RstLongSilenceLen  = 32'd1568;

  // Input operation codes.
  typedef enum logic {
    OP_WINDOW = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  // Reason a segment was closed.
  typedef enum logic [1:0] {
    CAUSE_SILENCE   = 2'd0,
    CAUSE_SPLIT     = 2'd1,
    CAUSE_FORCED    = 2'd2,
    CAUSE_STREAM_END = 2'd3
  } cause_e;

endpackage

`default_nettype wire

FILE: rtl/core/speech_segment_tracker.sv
// Speech segment tracker top level: hysteresis segmentation of per-window speech
// probabilities into start/end sample positions. Depends on sst_pkg.
//
// Channel   Dir  Signals                      Contents (low bits first)
// s_axis    in   tvalid/tready/tdata/tuser    tdata: voice_prob, tail_samples; tuser: operation
// m_axis    out  tvalid/tready/tdata/tuser    tdata: segment_start, segment_end; tuser: close_cause
// cfg       in   cfg_we_i/cfg_idx_i/cfg_wdata_i  register write, no read-back
//
// One item per clock while the output is not stalled; an item is held in the input register and
// its result is written from there into the output register.
// The state update for an item is one pass through an add, a subtract and compares.
// An item that produces a segment waits in the input register only while the output
// register still holds an untaken result; items without a result move on at once unless
// an earlier item with a result is still waiting ahead of them.
// Reset clears the stream state and loads the register defaults; there is no clearing pass.
`default_nettype none

module speech_segment_tracker #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [15:0] voice_prob, [31:16] tail_samples
  input  wire logic        s_axis_tuser_i,   // [0] operation

  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // [31:0] segment_start, [63:32] segment_end
  output logic [1:0]       m_axis_tuser_o,   // [1:0] close_cause

  input  wire logic                              cfg_we_i,
  input  wire logic [sst_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  wire logic [sst_pkg::LenBits-1:0]       cfg_wdata_i
);

  localparam int unsigned PW    = POSITION_BITS;
  localparam int unsigned CMP_W = (PW > sst_pkg::LenBits) ? PW : sst_pkg::LenBits;
  localparam int unsigned PB    = sst_pkg::ProbBits;

  typedef logic [PW-1:0]    pos_t;
  typedef logic [CMP_W-1:0] cmp_t;

  // Saturating add of a 16-bit amount to a position.
  function automatic pos_t sat_add(input pos_t a, input logic [PB-1:0] b);
    logic [PW:0] sum;
    sum = {1'b0, a} + (PW+1)'(b);
    return sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
  endfunction

  // Difference that stops at zero.
  function automatic pos_t floor_sub(input pos_t a, input pos_t b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // Configuration registers.
  logic [PB-1:0]                thr_q;
  logic [PB-1:0]                win_q;
  logic [sst_pkg::LenBits-1:0]  min_sil_q, min_speech_q, max_speech_q, long_sil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= sst_pkg::RstSpeechThreshold;
      win_q        <= sst_pkg::RstWindowSamples;
      min_sil_q    <= sst_pkg::RstMinSilenceLen;
      min_speech_q <= sst_pkg::RstMinSpeechLen;
      max_speech_q <= sst_pkg::RstMaxSpeechLen;
      long_sil_q   <= sst_pkg::RstLongSilenceLen;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sst_pkg::CFG_SPEECH_THRESHOLD: thr_q        <= cfg_wdata_i[PB-1:0];
        sst_pkg::CFG_WINDOW_SAMPLES:   win_q        <= cfg_wdata_i[PB-1:0];
        sst_pkg::CFG_MIN_SILENCE_LEN:  min_sil_q    <= cfg_wdata_i;
        sst_pkg::CFG_MIN_SPEECH_LEN:   min_speech_q <= cfg_wdata_i;
        sst_pkg::CFG_MAX_SPEECH_LEN:   max_speech_q <= cfg_wdata_i;
        sst_pkg::CFG_LONG_SILENCE_LEN: long_sil_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic          in_valid_q, in_valid_d;
  sst_pkg::op_e  op_q;
  logic [PB-1:0] prob_q, tail_q;
  logic          in_accept, advance;

  // Stream state; in_speech_q also marks that a segment is open.
  logic in_speech_q, in_speech_d;
  pos_t position_q, position_d;
  pos_t silence_start_q, silence_start_d;
  pos_t split_end_q, split_end_d;
  pos_t resume_start_q, resume_start_d;
  pos_t open_start_q, open_start_d;

  // Result register.
  logic            out_valid_q, out_valid_d;
  logic [31:0]     res_start_q, res_end_q;
  sst_pkg::cause_e res_cause_q;

  // Per-item evaluation.
  logic            emit_c;
  pos_t            res_start_c, res_end_c;
  sst_pkg::cause_e res_cause_c;
  pos_t            pos_add, win_start, ss_eff, quiet;
  logic            is_speech, below_band, too_long, long_quiet, may_close;

  assign pos_add    = sat_add(position_q, win_q);
  assign win_start  = floor_sub(pos_add, PW'(win_q));
  assign is_speech  = (prob_q >= thr_q);
  assign below_band = (thr_q >= sst_pkg::BandWidth) && (prob_q < (thr_q - sst_pkg::BandWidth));
  assign too_long   = in_speech_q &&
                      (CMP_W'(floor_sub(pos_add, open_start_q)) > CMP_W'(max_speech_q));
  assign ss_eff     = (silence_start_q == '0) ? pos_add : silence_start_q;
  assign quiet      = floor_sub(pos_add, ss_eff);
  assign long_quiet = CMP_W'(quiet) > CMP_W'(long_sil_q);
  assign may_close  = (CMP_W'(quiet) >= CMP_W'(min_sil_q)) &&
                      (CMP_W'(floor_sub(ss_eff, open_start_q)) > CMP_W'(min_speech_q));

  // Next stream state and the result of the item in the input register.
  always_comb begin
    in_speech_d     = in_speech_q;
    position_d      = position_q;
    silence_start_d = silence_start_q;
    split_end_d     = split_end_q;
    resume_start_d  = resume_start_q;
    open_start_d    = open_start_q;
    emit_c          = 1'b0;
    res_start_c     = open_start_q;
    res_end_c       = pos_add;
    res_cause_c     = sst_pkg::CAUSE_SILENCE;

    if (op_q == sst_pkg::OP_FLUSH) begin
      // End of stream: report the open segment and start over.
      emit_c          = in_speech_q;
      res_end_c       = sat_add(position_q, tail_q);
      res_cause_c     = sst_pkg::CAUSE_STREAM_END;
      in_speech_d     = 1'b0;
      position_d      = '0;
      silence_start_d = '0;
      split_end_d     = '0;
      resume_start_d  = '0;
      open_start_d    = '0;
    end else begin
      position_d = pos_add;
      if (is_speech) begin
        // Speech cancels a pending silence and opens a segment if none is open.
        if (silence_start_q != '0) begin
          silence_start_d = '0;
          if (resume_start_q < split_end_q) resume_start_d = win_start;
        end
        if (!in_speech_q) begin
          in_speech_d  = 1'b1;
          open_start_d = win_start;
        end
      end else if (too_long) begin
        // Over the maximum length: split at the remembered silence or force a close.
        emit_c = 1'b1;
        if (split_end_q != '0) begin
          res_end_c   = split_end_q;
          res_cause_c = sst_pkg::CAUSE_SPLIT;
          if (resume_start_q < split_end_q) begin
            in_speech_d  = 1'b0;
            open_start_d = '0;
          end else begin
            open_start_d = resume_start_q;
          end
        end else begin
          res_cause_c  = sst_pkg::CAUSE_FORCED;
          in_speech_d  = 1'b0;
          open_start_d = '0;
        end
        split_end_d     = '0;
        resume_start_d  = '0;
        silence_start_d = '0;
      end else if (below_band && in_speech_q) begin
        // Silence inside a segment: track it and close when long enough.
        silence_start_d = ss_eff;
        if (long_quiet) split_end_d = ss_eff;
        if (may_close) begin
          emit_c          = 1'b1;
          res_end_c       = ss_eff;
          res_cause_c     = sst_pkg::CAUSE_SILENCE;
          in_speech_d     = 1'b0;
          open_start_d    = '0;
          split_end_d     = '0;
          resume_start_d  = '0;
          silence_start_d = '0;
        end
      end
    end
  end

  // Handshake: an item without a result always moves on; one with a result needs room.
  assign advance         = in_valid_q && (!emit_c || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)    in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance && emit_c)     out_valid_d = 1'b1;
    else if (m_axis_tready_i)  out_valid_d = 1'b0;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      in_speech_q     <= 1'b0;
      position_q      <= '0;
      silence_start_q <= '0;
      split_end_q     <= '0;
      resume_start_q  <= '0;
      open_start_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        in_speech_q     <= in_speech_d;
        position_q      <= position_d;
        silence_start_q <= silence_start_d;
        split_end_q     <= split_end_d;
        resume_start_q  <= resume_start_d;
        open_start_q    <= open_start_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= sst_pkg::op_e'(s_axis_tuser_i);
      prob_q <= s_axis_tdata_i[15:0];
      tail_q <= s_axis_tdata_i[31:16];
    end
    if (advance && emit_c) begin
      res_start_q <= 32'(res_start_c);
      res_end_q   <= 32'(res_end_c);
      res_cause_q <= res_cause_c;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {res_end_q, res_start_q};
  assign m_axis_tuser_o  = res_cause_q;

  // Outside a segment no marks are left behind.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_speech_q |-> (silence_start_q == '0 && split_end_q == '0 &&
                      resume_start_q == '0 && open_start_q == '0))
    else $error("stale segment marks outside a segment");

  // A split point never lies ahead of the current position.
  a_split_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_end_q <= position_q)
    else $error("split point beyond position");

  // The position only moves forward between flushes.
  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op_q == sst_pkg::OP_WINDOW) |=> position_q >= $past(position_q))
    else $error("position moved backward");

  // A flush returns the stream to its start.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op_q == sst_pkg::OP_FLUSH) |=> (position_q == '0 && !in_speech_q))
    else $error("flush did not clear the stream state");

endmodule

`default_nettype wire
